### src/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

  // Command queue between front and back; depth must be a power of two.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWA   = 8'h61;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  typedef enum logic [1:0] {
    CMD_LIT,   // one byte as is
    CMD_ESC2,  // backslash, then data
    CMD_UESC   // backslash u 0 0 hex hex of data
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } cmd_t;

  // Lowercase hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CH_ZERO + {4'd0, n};
    end else begin
      r = CH_LOWA + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

  // Full sequence length announced by a lead byte, zero if not a lead.
  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] r;
    if (b[7:5] == 3'b110) begin
      r = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      r = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      r = 3'd4;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

### src/jse_fifo.sv
`timescale 1ns / 1ps

module jse_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  jse_pkg::cmd_t wdata,
  output logic          q_full,
  input  logic          rd,
  output jse_pkg::cmd_t head,
  output logic          q_empty
);
  import jse_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;

  assign q_full  = (cnt == QDEPTH[QAW:0]);
  assign q_empty = (cnt == '0);
  assign head    = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

### src/jse_front.sv
`timescale 1ns / 1ps

module jse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          push,
  output logic          full,
  output logic          q_wr,
  output jse_pkg::cmd_t q_wdata,
  input  logic          q_full
);
  import jse_pkg::*;

  // Held input word
  logic       hvalid;
  logic [7:0] hb;
  logic       hlast;

  // Pending UTF-8 sequence
  logic [7:0] pend [3];
  logic [1:0] pcount;
  logic [2:0] explen;

  // Step within the current word, and truncation release mode
  logic [1:0] k;
  logic       rel;

  logic [1:0] pcount_next;
  logic [2:0] explen_next;
  logic [1:0] k_next;
  logic       rel_next;
  logic       pend_we;
  logic [1:0] pend_wi;
  logic [7:0] pend_rd;
  logic       emit;
  logic       fin;
  logic       go;
  logic       accept;
  logic       cont;
  logic       complete;
  logic       lastk_rel;
  logic [2:0] lead_len;
  cmd_t       cmd;

  assign cont      = (hb[7:6] == 2'b10);
  assign complete  = (({1'b0, pcount} + 3'd1) >= explen);
  assign lastk_rel = (k == (pcount - 2'd1));
  assign lead_len  = seq_length(hb);

  always_comb begin
    case (k)
      2'd1:    pend_rd = pend[1];
      2'd2:    pend_rd = pend[2];
      default: pend_rd = pend[0];
    endcase
  end

  always_comb begin
    emit        = 1'b0;
    fin         = 1'b0;
    cmd         = '0;
    pcount_next = pcount;
    explen_next = explen;
    k_next      = k;
    rel_next    = rel;
    pend_we     = 1'b0;
    pend_wi     = pcount;
    if (rel) begin
      // string ended inside a sequence: escape each held byte
      emit           = 1'b1;
      cmd.kind       = CMD_UESC;
      cmd.data       = pend_rd;
      cmd.run_last   = lastk_rel;
      cmd.string_end = lastk_rel & hlast;
      if (lastk_rel) begin
        pcount_next = '0;
        explen_next = '0;
        k_next      = '0;
        rel_next    = 1'b0;
        fin         = 1'b1;
      end else begin
        k_next = k + 2'd1;
      end
    end else if (pcount != 2'd0 && cont && complete) begin
      // sequence complete: pass held bytes, then this one
      emit           = 1'b1;
      cmd.kind       = CMD_LIT;
      cmd.data       = (k == pcount) ? hb : pend_rd;
      cmd.run_last   = (k == pcount);
      cmd.string_end = (k == pcount) & hlast;
      if (k == pcount) begin
        pcount_next = '0;
        explen_next = '0;
        k_next      = '0;
        fin         = 1'b1;
      end else begin
        k_next = k + 2'd1;
      end
    end else if (pcount != 2'd0 && cont) begin
      // extend the held sequence
      pend_we     = 1'b1;
      pend_wi     = pcount;
      pcount_next = pcount + 2'd1;
      if (hlast) begin
        rel_next = 1'b1;
      end else begin
        fin = 1'b1;
      end
    end else if (pcount != 2'd0) begin
      // broken sequence: escape held bytes, then treat word as fresh;
      // the last escape ends the run when the fresh byte is a lead that
      // gets held and so adds nothing
      emit         = 1'b1;
      cmd.kind     = CMD_UESC;
      cmd.data     = pend_rd;
      cmd.run_last = lastk_rel && (lead_len != 3'd0) && !hlast;
      if (lastk_rel) begin
        pcount_next = '0;
        explen_next = '0;
        k_next      = '0;
      end else begin
        k_next = k + 2'd1;
      end
    end else begin
      cmd.run_last   = 1'b1;
      cmd.string_end = hlast;
      cmd.data       = hb;
      fin            = 1'b1;
      if (!hb[7]) begin
        emit = 1'b1;
        case (hb)
          CH_QUOTE: begin
            cmd.kind = CMD_ESC2;
            cmd.data = CH_QUOTE;
          end
          CH_BSLASH: begin
            cmd.kind = CMD_ESC2;
            cmd.data = CH_BSLASH;
          end
          CH_LF: begin
            cmd.kind = CMD_ESC2;
            cmd.data = CH_N;
          end
          CH_CR: begin
            cmd.kind = CMD_ESC2;
            cmd.data = CH_R;
          end
          CH_TAB: begin
            cmd.kind = CMD_ESC2;
            cmd.data = CH_T;
          end
          default: begin
            cmd.kind = (hb < CTRL_TOP) ? CMD_UESC : CMD_LIT;
          end
        endcase
      end else if (lead_len != 3'd0 && !hlast) begin
        // hold the lead byte
        pend_we     = 1'b1;
        pend_wi     = 2'd0;
        pcount_next = 2'd1;
        explen_next = lead_len;
      end else begin
        // stray byte, or lead byte that ends the string
        emit     = 1'b1;
        cmd.kind = CMD_UESC;
      end
    end
  end

  assign go      = hvalid && !(emit && q_full);
  assign full    = hvalid && !(go && fin);
  assign accept  = push && !full;
  assign q_wr    = hvalid && emit && !q_full;
  assign q_wdata = cmd;

  always_ff @(posedge clk) begin
    if (accept) begin
      hb    <= in_byte;
      hlast <= in_last;
    end
    if (go && pend_we) begin
      case (pend_wi)
        2'd1:    pend[1] <= hb;
        2'd2:    pend[2] <= hb;
        default: pend[0] <= hb;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= 1'b0;
      pcount <= '0;
      explen <= '0;
      k      <= '0;
      rel    <= 1'b0;
    end else begin
      if (accept) begin
        hvalid <= 1'b1;
      end else if (go && fin) begin
        hvalid <= 1'b0;
      end
      if (go) begin
        pcount <= pcount_next;
        explen <= explen_next;
        k      <= k_next;
        rel    <= rel_next;
      end
    end
  end

endmodule

### src/jse_back.sv
`timescale 1ns / 1ps

module jse_back (
  input  logic          clk,
  input  logic          rst,
  input  jse_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_rd,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          string_end,
  output logic          empty,
  input  logic          pop
);
  import jse_pkg::*;

  logic [2:0] j;
  logic       ovalid;
  logic [7:0] nbyte;
  logic       lastb;
  logic       load;

  always_comb begin
    nbyte = head.data;
    lastb = 1'b1;
    case (head.kind)
      CMD_ESC2: begin
        lastb = (j == 3'd1);
        nbyte = (j == 3'd0) ? CH_BSLASH : head.data;
      end
      CMD_UESC: begin
        lastb = (j == 3'd5);
        case (j)
          3'd0:    nbyte = CH_BSLASH;
          3'd1:    nbyte = CH_U;
          3'd2:    nbyte = CH_ZERO;
          3'd3:    nbyte = CH_ZERO;
          3'd4:    nbyte = hex_digit(head.data[7:4]);
          default: nbyte = hex_digit(head.data[3:0]);
        endcase
      end
      default: begin
        lastb = 1'b1;
        nbyte = head.data;
      end
    endcase
  end

  assign load  = !q_empty && (!ovalid || pop);
  assign q_rd  = load && lastb;
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= nbyte;
      run_last   <= head.run_last & lastb;
      string_end <= head.string_end & lastb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      j      <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        j      <= lastb ? 3'd0 : j + 3'd1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

endmodule

### src/json_string_escaper_utf8.sv
`timescale 1ns / 1ps

// JSON string escaper with UTF-8 sequence checking. Bytes go in through a
// push/full queue port, with in_last on the final byte of a string; escaped
// bytes come out through an empty/pop queue port. Quote, backslash, LF, CR
// and TAB become two-byte escapes; other control bytes become \u00xx in
// lowercase hex; other ASCII passes through. A UTF-8 lead byte is held until
// its continuations arrive, then the whole sequence passes through; a broken
// or truncated sequence escapes each held byte as \u00xx and looks at the
// next byte afresh. run_last marks the last output byte caused by one input
// word, string_end the last output byte of a string.
// The front takes one input word per cycle when it yields at most one
// command and the queue is not full; a held sequence it releases issues
// its commands in turn before the next word (up to four for a completed
// sequence, up to three escapes plus one for a broken one). A string that
// ends inside a sequence has its last byte held, then each held byte is
// escaped (up to three). The back turns each command into output bytes
// at one byte per cycle while popped: one for a plain byte, two for a
// short escape, six for \u00xx. A four-deep command queue sits between
// them, so popped plain text runs at one byte per cycle and escapes
// throttle the input only once the queue fills. Output is registered.

module json_string_escaper_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end,
  output logic       empty,
  input  logic       pop
);
  import jse_pkg::*;

  // front to queue
  logic q_wr;
  cmd_t q_wdata;
  logic q_full;

  // queue to back
  logic q_rd;
  cmd_t q_head;
  logic q_empty;

  // Classify input words, track pending UTF-8 sequences, issue commands.
  jse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .full    (full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  // Decouple front from back.
  jse_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .head    (q_head),
    .q_empty (q_empty)
  );

  // Expand each command into output bytes.
  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_rd       (q_rd),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
